/* hdl/iii_pkg.sv */
// Shared types and constants for the inverted integral image block.
// No dependencies; used by every module of the block except iii_line_mem.
package iii_pkg;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 28;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int SIZE_RESET     = 1024;

  localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // per-pixel flags handed from the scan counters to the sum stage
  typedef struct packed {
    logic first_row;
    logic frame_last;
  } tag_t;

endpackage

/* hdl/iii_line_mem.sv */
// Line store: simple dual-port RAM, one write and one registered read port.
// Depends on nothing; instantiated by inverted_integral_image.
module iii_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/iii_scan.sv */
// Raster scan control: frame size registers, column/row counters, row running sum.
// Depends on iii_pkg.
module iii_scan #(
  parameter int MAX_WIDTH  = iii_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iii_pkg::MAX_HEIGHT_DEF,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int RS_W       = 18
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [iii_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iii_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           advance,
  input  logic [iii_pkg::PIX_W-1:0]      pixel_value,
  output logic [COL_W-1:0]               col,
  output logic [RS_W-1:0]                row_sum_now,
  output iii_pkg::tag_t                  tag
);

  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WLIM_W = COL_W + 1;
  localparam int HLIM_W = ROW_W + 1;
  localparam int W_RST  = (iii_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : iii_pkg::SIZE_RESET;
  localparam int H_RST  = (iii_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : iii_pkg::SIZE_RESET;

  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [RS_W-1:0]   row_sum;
  logic [WLIM_W-1:0] width_lim;
  logic [HLIM_W-1:0] height_lim;
  logic [WLIM_W-1:0] width_in;
  logic [HLIM_W-1:0] height_in;
  logic [iii_pkg::PIX_W-1:0] inv;
  logic row_end;
  logic frame_end;

  // sizes are clamped to 1..MAX on write
  always_comb begin
    if (cfg_data == '0) begin
      width_in  = WLIM_W'(1);
      height_in = HLIM_W'(1);
    end else begin
      width_in  = (int'(cfg_data) > MAX_WIDTH)  ? WLIM_W'(MAX_WIDTH)  : WLIM_W'(cfg_data);
      height_in = (int'(cfg_data) > MAX_HEIGHT) ? HLIM_W'(MAX_HEIGHT) : HLIM_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= WLIM_W'(W_RST);
      height_lim <= HLIM_W'(H_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        iii_pkg::CFG_FRAME_WIDTH:  width_lim  <= width_in;
        iii_pkg::CFG_FRAME_HEIGHT: height_lim <= height_in;
        default: ;
      endcase
    end
  end

  assign inv       = iii_pkg::PIX_FULL - pixel_value;
  assign row_end   = (WLIM_W'(col_pos) + WLIM_W'(1)) >= width_lim;
  assign frame_end = row_end && ((HLIM_W'(row_pos) + HLIM_W'(1)) >= height_lim);

  assign col            = col_pos;
  assign row_sum_now    = (col_pos == '0) ? RS_W'(inv) : row_sum + RS_W'(inv);
  assign tag.first_row  = (row_pos == '0);
  assign tag.frame_last = frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      row_sum <= '0;
    end else if (advance) begin
      row_sum <= row_sum_now;
      if (row_end) begin
        col_pos <= '0;
        row_pos <= frame_end ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

endmodule

/* hdl/inverted_integral_image.sv */
// Inverted integral image: streams 8-bit pixels in raster order and returns, per pixel,
// the summed-area value of (255 - pixel) from the origin to that pixel, with frame_last
// on the frame's final pixel. One pixel per clock is sustained while the output side
// does not stall. Each result passes the sum stage, which adds the line-store read
// launched at pixel transfer, then the output register. The rate is set by the line
// store, a RAM with one write and one read port: the previous row's sum for a column
// is read at pixel transfer and the new sum written back when that pixel leaves the sum
// stage; a one-column frame forwards the value being written. The input stalls only
// while both the sum stage and the output register hold a result that the output side
// is stalling, and throughout reset. Frame size registers are written through the cfg
// channel (ready whenever out of reset), by the user only while the stream is idle,
// unenforced by the block; sizes are clamped to 1..MAX. The line store needs no clearing:
// the first row ignores what it reads. Depends on iii_pkg, iii_scan, iii_line_mem.
module inverted_integral_image #(
  parameter int MAX_WIDTH  = iii_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iii_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iii_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iii_pkg::CFG_W-1:0]      cfg_data,
  // pixel channel
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic [iii_pkg::PIX_W-1:0]      pixel_value,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [iii_pkg::SUM_W-1:0]      area_sum,
  output logic                           frame_last
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RS_RAW = $clog2(255 * MAX_WIDTH + 1);
  localparam int RS_W   = (RS_RAW > iii_pkg::SUM_W) ? iii_pkg::SUM_W : RS_RAW;
  localparam int SUM_W  = iii_pkg::SUM_W;

  logic             accept;
  logic             out_load;
  logic             s1_move;

  logic [COL_W-1:0] scan_col;
  logic [RS_W-1:0]  scan_rs;
  iii_pkg::tag_t    scan_tag;

  // sum stage: item whose line-store read is in flight
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [RS_W-1:0]  s1_rs;
  iii_pkg::tag_t    s1_tag;
  logic             fwd_hit;
  logic [SUM_W-1:0] fwd_data;
  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] above;
  logic [SUM_W-1:0] total;

  assign cfg_ready = !rst;

  // the sum stage drains into the output register whenever that register is free
  // or being emptied; a new pixel enters whenever the sum stage is empty or being emptied
  assign out_load    = !result_valid || !result_stall;
  assign s1_move     = s1_valid && out_load;
  assign pixel_stall = rst || (s1_valid && !out_load);
  assign accept      = pixel_valid && !pixel_stall;

  iii_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .RS_W       (RS_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (accept),
    .pixel_value (pixel_value),
    .col         (scan_col),
    .row_sum_now (scan_rs),
    .tag         (scan_tag)
  );

  // read at transfer, write back as the item leaves the sum stage
  iii_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W),
    .DATA_W (SUM_W)
  ) u_line (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col),
    .wdata (total),
    .re    (accept),
    .raddr (scan_col),
    .rdata (rd_data)
  );

  // a read that collides with the write of the same column (one-column frame)
  // sees stale RAM data, so take the written value instead
  assign above = fwd_hit ? fwd_data : rd_data;
  assign total = s1_tag.first_row ? SUM_W'(s1_rs) : above + SUM_W'(s1_rs);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= scan_col;
      s1_rs    <= scan_rs;
      s1_tag   <= scan_tag;
      fwd_hit  <= s1_move && (s1_col == scan_col);
      fwd_data <= total;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      area_sum   <= total;
      frame_last <= s1_tag.frame_last;
    end
  end

endmodule

/* hdl/iii_checker.sv */
// Port-level checks for inverted_integral_image, bound to the top level.
// Depends on iii_pkg and inverted_integral_image.
module iii_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_valid,
  input logic                      pixel_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic [iii_pkg::SUM_W-1:0] area_sum,
  input logic                      frame_last
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] in_flight;

  assign in_xfer  = pixel_valid && !pixel_stall;
  assign out_xfer = result_valid && !result_stall;

  // pixels taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_depth: assert property (@(posedge clk) disable iff (rst) in_flight != 2'd3)
    else $error("more than two pixels in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> in_flight != 2'd0)
    else $error("result with no pixel behind it");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (result_valid && result_stall))
    else $error("input stalled while output side is free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> ($stable(area_sum) && $stable(frame_last)))
    else $error("stalled result changed");

endmodule

bind inverted_integral_image iii_checker u_iii_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .area_sum     (area_sum),
  .frame_last   (frame_last)
);
